// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is asserted.
`define ASSERT_CLKRST(label, clk_sig, rstn_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKRST(label, clk, rst_n, prop, msg)

`endif

// ===== src/imaenc_pkg.sv =====
// ----------------------------------------------------------------------------
// imaenc_pkg
// Widths, limits and tables of the IMA ADPCM encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imaenc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 7;
  localparam int STEP_W   = 15;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + 2;

  localparam logic [IDX_W-1:0]        IDX_MAX  = 7'd88;
  localparam logic signed [SUM_W-1:0] PRED_MAX = 18'sd32767;
  localparam logic signed [SUM_W-1:0] PRED_MIN = -18'sd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CODE_W-1:0]          code_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [STEP_W-1:0]          step_t;

  function automatic step_t step_size(input idx_t idx);
    case (idx)
      7'd0:  return 15'd7;     7'd1:  return 15'd8;     7'd2:  return 15'd9;
      7'd3:  return 15'd10;    7'd4:  return 15'd11;    7'd5:  return 15'd12;
      7'd6:  return 15'd13;    7'd7:  return 15'd14;    7'd8:  return 15'd16;
      7'd9:  return 15'd17;    7'd10: return 15'd19;    7'd11: return 15'd21;
      7'd12: return 15'd23;    7'd13: return 15'd25;    7'd14: return 15'd28;
      7'd15: return 15'd31;    7'd16: return 15'd34;    7'd17: return 15'd37;
      7'd18: return 15'd41;    7'd19: return 15'd45;    7'd20: return 15'd50;
      7'd21: return 15'd55;    7'd22: return 15'd60;    7'd23: return 15'd66;
      7'd24: return 15'd73;    7'd25: return 15'd80;    7'd26: return 15'd88;
      7'd27: return 15'd97;    7'd28: return 15'd107;   7'd29: return 15'd118;
      7'd30: return 15'd130;   7'd31: return 15'd143;   7'd32: return 15'd157;
      7'd33: return 15'd173;   7'd34: return 15'd190;   7'd35: return 15'd209;
      7'd36: return 15'd230;   7'd37: return 15'd253;   7'd38: return 15'd279;
      7'd39: return 15'd307;   7'd40: return 15'd337;   7'd41: return 15'd371;
      7'd42: return 15'd408;   7'd43: return 15'd449;   7'd44: return 15'd494;
      7'd45: return 15'd544;   7'd46: return 15'd598;   7'd47: return 15'd658;
      7'd48: return 15'd724;   7'd49: return 15'd796;   7'd50: return 15'd876;
      7'd51: return 15'd963;   7'd52: return 15'd1060;  7'd53: return 15'd1166;
      7'd54: return 15'd1282;  7'd55: return 15'd1411;  7'd56: return 15'd1552;
      7'd57: return 15'd1707;  7'd58: return 15'd1878;  7'd59: return 15'd2066;
      7'd60: return 15'd2272;  7'd61: return 15'd2499;  7'd62: return 15'd2749;
      7'd63: return 15'd3024;  7'd64: return 15'd3327;  7'd65: return 15'd3660;
      7'd66: return 15'd4026;  7'd67: return 15'd4428;  7'd68: return 15'd4871;
      7'd69: return 15'd5358;  7'd70: return 15'd5894;  7'd71: return 15'd6484;
      7'd72: return 15'd7132;  7'd73: return 15'd7845;  7'd74: return 15'd8630;
      7'd75: return 15'd9493;  7'd76: return 15'd10442; 7'd77: return 15'd11487;
      7'd78: return 15'd12635; 7'd79: return 15'd13899; 7'd80: return 15'd15289;
      7'd81: return 15'd16818; 7'd82: return 15'd18500; 7'd83: return 15'd20350;
      7'd84: return 15'd22385; 7'd85: return 15'd24623; 7'd86: return 15'd27086;
      7'd87: return 15'd29794;
      default: return 15'd32767;
    endcase
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    case (mag)
      3'd4:    return 5'sd2;
      3'd5:    return 5'sd4;
      3'd6:    return 5'sd6;
      3'd7:    return 5'sd8;
      default: return -5'sd1;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== src/imaenc_if.sv =====
// ----------------------------------------------------------------------------
// imaenc_in_if / imaenc_out_if
// Valid/ready channels carrying PCM samples in and packed code bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface imaenc_in_if import imaenc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface imaenc_out_if import imaenc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              frame_done;

  modport source (output valid, output packed_byte, output frame_done, input ready);
  modport sink   (input valid, input packed_byte, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== src/ima_adpcm_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// ima_adpcm_encoder_unit
// A sample is held in the input register while encoded; a byte it completes is
// registered, then valid on the output. Throughput: one sample per cycle unless
// the output stalls a byte-ending sample, set by the single encode stage between
// the input and byte registers; one byte per two samples or per frame end.
// Reset (rst_n low, synchronous) clears predictor, step index, pending
// nibble and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_encoder_unit import imaenc_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  imaenc_in_if.sink    in_ch,
  imaenc_out_if.source out_ch
);

  logic                 s1_vld_r;
  sample_t              sample_r;
  logic                 fe_r;

  logic signed [SAMPLE_W-1:0] pred_r, pred_nxt;
  idx_t                 idx_r, idx_nxt;
  logic                 pending_r;
  code_t                held_r;

  logic                 out_vld_r;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic                 done_r;

  logic                 emit, out_free, fire;
  code_t                code;

  step_t                step;
  logic [DIFF_W-1:0]    step_e, step_h, step_q, absd, rem1, rem2, vpdiff;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W-1:0]  pred_sum;
  logic signed [IDX_W:0]    idx_sum;
  logic                 sgn, b2, b1, b0;

  always_comb begin
    step   = step_size(idx_r);
    step_e = {{(DIFF_W-STEP_W){1'b0}}, step};
    step_h = step_e >> 1;
    step_q = step_e >> 2;
    diff   = {sample_r[SAMPLE_W-1], sample_r} - {pred_r[SAMPLE_W-1], pred_r};
    sgn    = diff[DIFF_W-1];
    absd   = sgn ? DIFF_W'(-diff) : DIFF_W'(diff);
    b2     = absd >= step_e;
    rem1   = b2 ? absd - step_e : absd;
    b1     = rem1 >= step_h;
    rem2   = b1 ? rem1 - step_h : rem1;
    b0     = rem2 >= step_q;
    vpdiff = (step_e >> 3) + (b2 ? step_e : '0) + (b1 ? step_h : '0)
           + (b0 ? step_q : '0);
    code   = {sgn, b2, b1, b0};

    pred_sum = sgn ? {{2{pred_r[SAMPLE_W-1]}}, pred_r} - {1'b0, vpdiff}
                   : {{2{pred_r[SAMPLE_W-1]}}, pred_r} + {1'b0, vpdiff};
    if (pred_sum > PRED_MAX) begin
      pred_nxt = SAMPLE_W'(PRED_MAX);
    end else if (pred_sum < PRED_MIN) begin
      pred_nxt = SAMPLE_W'(PRED_MIN);
    end else begin
      pred_nxt = pred_sum[SAMPLE_W-1:0];
    end

    idx_sum = $signed({1'b0, idx_r}) + (IDX_W+1)'(index_adjust(code[2:0]));
    if (idx_sum < 0) begin
      idx_nxt = '0;
    end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
      idx_nxt = IDX_MAX;
    end else begin
      idx_nxt = idx_sum[IDX_W-1:0];
    end

    byte_nxt = pending_r ? {held_r, code} : {code, {CODE_W{1'b0}}};
  end

  assign emit     = pending_r || fe_r;
  assign out_free = !out_vld_r || out_ch.ready;
  assign fire     = s1_vld_r && (!emit || out_free);

  assign in_ch.ready        = !s1_vld_r || fire;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.packed_byte = byte_r;
  assign out_ch.frame_done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pending_r <= 1'b0;
      held_r    <= '0;
      pred_r    <= '0;
      idx_r     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_vld_r <= 1'b1;
        sample_r <= in_ch.sample;
        fe_r     <= in_ch.frame_end;
      end else if (fire) begin
        s1_vld_r <= 1'b0;
      end

      if (fire) begin
        pred_r    <= pred_nxt;
        idx_r     <= idx_nxt;
        pending_r <= !emit;
        held_r    <= emit ? '0 : code;
      end

      if (fire && emit) begin
        out_vld_r <= 1'b1;
        byte_r    <= byte_nxt;
        done_r    <= fe_r;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/imaenc_checker.sv =====
// ----------------------------------------------------------------------------
// imaenc_checker
// Port-level checks of the IMA ADPCM encoder handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module imaenc_checker import imaenc_pkg::*; (
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire [BYTE_W-1:0] out_packed_byte,
  input wire              out_frame_done
);

  `ASSERT_STD(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_packed_byte) && $stable(out_frame_done)), "output beat changed while stalled")

  `ASSERT_STD(a_stall_cause, !in_ready |-> (out_valid && !out_ready), "input stalled without output backpressure")

  `ASSERT_STD(a_out_source, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "output beat without a sample two cycles earlier")

endmodule

bind ima_adpcm_encoder_unit imaenc_checker u_imaenc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_packed_byte (out_ch.packed_byte),
  .out_frame_done  (out_ch.frame_done)
);

`default_nettype wire
